// File: rtl/polygon_outlier_rejecting_smoother_assert.svh
// assertion macros for the polygon smoother
`ifndef POLYGON_OUTLIER_REJECTING_SMOOTHER_ASSERT_SVH
`define POLYGON_OUTLIER_REJECTING_SMOOTHER_ASSERT_SVH
// implication checked every clock outside reset
`define POS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked every clock outside reset
`define POS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/pors_pkg.sv
// shared types and constants for the polygon smoother
package pors_pkg;
    localparam int HISTORY_DEPTH = 16;
    localparam int COORD_WIDTH   = 16;
    localparam int NCOORD        = 8;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int CFG_W         = 5;
    localparam int POLY_W        = NCOORD * COORD_WIDTH;
    // sum of up to HISTORY_DEPTH coordinates
    localparam int SUM_W         = COORD_WIDTH + FILL_W + 1;
    // l1 distance over eight coordinates
    localparam int DIST_W        = COORD_WIDTH + 5;
    localparam int CNT_W         = $clog2(SUM_W + 1);

    localparam logic [0:0] CFG_KEEP_COUNT    = 1'b0;
    localparam logic [0:0] CFG_AVERAGE_COUNT = 1'b1;
    localparam int         CFG_ADDR_W        = 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] bottom_left_x;
        logic signed [COORD_WIDTH-1:0] bottom_left_y;
        logic signed [COORD_WIDTH-1:0] bottom_right_x;
        logic signed [COORD_WIDTH-1:0] bottom_right_y;
        logic signed [COORD_WIDTH-1:0] top_right_x;
        logic signed [COORD_WIDTH-1:0] top_right_y;
        logic signed [COORD_WIDTH-1:0] top_left_x;
        logic signed [COORD_WIDTH-1:0] top_left_y;
    } poly_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] smooth_bottom_left_x;
        logic signed [COORD_WIDTH-1:0] smooth_bottom_left_y;
        logic signed [COORD_WIDTH-1:0] smooth_bottom_right_x;
        logic signed [COORD_WIDTH-1:0] smooth_bottom_right_y;
        logic signed [COORD_WIDTH-1:0] smooth_top_right_x;
        logic signed [COORD_WIDTH-1:0] smooth_top_right_y;
        logic signed [COORD_WIDTH-1:0] smooth_top_left_x;
        logic signed [COORD_WIDTH-1:0] smooth_top_left_y;
    } poly_out_t;

    // divider handshake between sequencer and divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

// File: rtl/polygon_outlier_rejecting_smoother.sv
// top level: history fifo, sequencer and shared divider of the polygon smoother
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_valid / s_ready      | s_data   (pors_pkg::poly_in_t)
//  m_      | out       | m_valid / m_ready      | m_data   (pors_pkg::poly_out_t)
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_addr, cfg_data
//
// after acceptance a request spends a write step, a sum pass over the history
// and eight divisions; with enough valid entries it adds a distance pass, avg
// picks, an accumulate step and eight more divisions; with nothing valid the
// input passes through undivided.
// reset is synchronous active low; s_ready is low until the result is taken on m_.
module polygon_outlier_rejecting_smoother (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pors_pkg::poly_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pors_pkg::poly_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pors_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pors_pkg::CFG_W-1:0]          cfg_data
);
    localparam int CW = pors_pkg::COORD_WIDTH;
    localparam int SW = pors_pkg::SLOT_W;
    localparam int FW = pors_pkg::FILL_W;
    localparam int NC = pors_pkg::NCOORD;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRITE, ST_SUM_RD, ST_SUM_ACC, ST_DIV1, ST_DIST_RD,
        ST_DIST_ACC, ST_SEL_RD, ST_SEL_ACC, ST_SEL_ADD_RD, ST_SEL_ADD,
        ST_DIV2, ST_OUT
    } state_t;

    state_t                        state_reg;
    logic [pors_pkg::CFG_W-1:0]    keep_reg, avg_reg;
    logic [FW-1:0]                 fill_reg;
    logic [SW-1:0]                 oldest_reg;
    logic [FW-1:0]                 keep_c, avg_c, valid_reg;
    logic [FW-1:0]                 age_reg, k_reg, best_reg;
    logic [pors_pkg::DIST_W-1:0]   best_d_reg;
    logic [pors_pkg::DIST_W-1:0]   dist_reg [pors_pkg::HISTORY_DEPTH];
    logic [pors_pkg::DIST_W-1:0]   dacc_reg;
    logic [pors_pkg::HISTORY_DEPTH-1:0] taken_reg;
    logic signed [pors_pkg::SUM_W-1:0] sum_reg [NC];
    logic signed [CW-1:0]          mean_reg [NC];
    logic [2:0]                    j_reg;
    logic                          second_reg;
    pors_pkg::poly_in_t            in_reg;
    pors_pkg::poly_out_t           out_reg;

    logic                          ram_we;
    logic [SW-1:0]                 ram_addr;
    logic [pors_pkg::POLY_W-1:0]   ram_rdata;
    logic signed [CW-1:0]          rd_c [NC];
    logic signed [CW-1:0]          in_c [NC];
    logic [pors_pkg::DIST_W-1:0]   dist_c;
    logic signed [CW:0]            diff_c;

    pors_pkg::div_ctl_t            div_ctl;
    logic signed [CW-1:0]          div_q;
    logic [FW-1:0]                 div_den;

    // clamp the window and average counts
    always_comb begin
        keep_c = (keep_reg == '0) ? FW'(1)
               : (keep_reg > pors_pkg::CFG_W'(pors_pkg::HISTORY_DEPTH))
                 ? FW'(pors_pkg::HISTORY_DEPTH) : FW'(keep_reg);
        avg_c  = (avg_reg == '0) ? FW'(1) : FW'(avg_reg);
    end

    // unpack coordinates, word 0 is bottom_left_x in the msbs
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            rd_c[i] = ram_rdata[pors_pkg::POLY_W-1-i*CW -: CW];
            in_c[i] = in_reg[pors_pkg::POLY_W-1-i*CW -: CW];
        end
    end

    // l1 distance of the read entry from the mean, one coordinate per cycle
    always_comb begin
        diff_c = (CW+1)'(mean_reg[j_reg]) - (CW+1)'(rd_c[j_reg]);
        dist_c = dacc_reg + pors_pkg::DIST_W'(diff_c[CW] ? -diff_c : diff_c);
    end

    // history address: slot of age, slot of best for the pick read, write at slot of fill
    always_comb begin
        ram_we   = (state_reg == ST_WRITE);
        ram_addr = SW'(oldest_reg + SW'(state_reg == ST_WRITE ? fill_reg
                 : (state_reg == ST_SEL_ADD_RD ? best_reg : age_reg)));
    end

    pors_ram #(.WIDTH(pors_pkg::POLY_W), .DEPTH(pors_pkg::HISTORY_DEPTH)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_reg),
        .rdata (ram_rdata)
    );

    // no division when nothing is valid, the input passes through
    assign div_den = second_reg ? avg_c : valid_reg;
    assign div_ctl.start = (state_reg == ST_DIV1 || state_reg == ST_DIV2)
                         && !div_ctl.busy && !div_ctl.done
                         && (second_reg || valid_reg != '0);

    pors_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .dividend (sum_reg[j_reg]),
        .divisor  (div_den),
        .busy     (div_ctl.busy),
        .quotient (div_q)
    );

    logic div_run_reg;
    assign div_ctl.done = div_run_reg && !div_ctl.busy;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_data    = out_reg;
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            keep_reg    <= pors_pkg::CFG_W'(10);
            avg_reg     <= pors_pkg::CFG_W'(5);
            fill_reg    <= '0;
            oldest_reg  <= '0;
            div_run_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    pors_pkg::CFG_KEEP_COUNT:    keep_reg <= cfg_data;
                    pors_pkg::CFG_AVERAGE_COUNT: avg_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (div_ctl.start) div_run_reg <= 1'b1;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        if (fill_reg >= FW'(pors_pkg::HISTORY_DEPTH)) begin
                            oldest_reg <= oldest_reg + 1'b1;
                            fill_reg   <= fill_reg - 1'b1;
                        end
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    // push then trim down to the window in one step
                    if (fill_reg + 1'b1 > keep_c) begin
                        oldest_reg <= SW'(oldest_reg + SW'(fill_reg + 1'b1 - keep_c));
                        fill_reg   <= keep_c;
                    end else begin
                        fill_reg   <= fill_reg + 1'b1;
                    end
                    for (int i = 0; i < NC; i++) sum_reg[i] <= '0;
                    valid_reg  <= '0;
                    age_reg    <= '0;
                    second_reg <= 1'b0;
                    state_reg  <= ST_SUM_RD;
                end
                ST_SUM_RD: begin
                    state_reg <= (age_reg == fill_reg) ? ST_DIV1 : ST_SUM_ACC;
                    j_reg     <= '0;
                end
                ST_SUM_ACC: begin
                    if (rd_c[0] != '0 || rd_c[1] != '0) begin
                        valid_reg <= valid_reg + 1'b1;
                        for (int i = 0; i < NC; i++)
                            sum_reg[i] <= sum_reg[i] + pors_pkg::SUM_W'(rd_c[i]);
                    end
                    age_reg   <= age_reg + 1'b1;
                    state_reg <= ST_SUM_RD;
                end
                ST_DIV1, ST_DIV2: begin
                    if (!second_reg && valid_reg == '0) begin
                        for (int i = 0; i < NC; i++) out_reg[pors_pkg::POLY_W-1-i*CW -: CW] <= in_c[i];
                        state_reg <= ST_OUT;
                    end else if (div_ctl.done) begin
                        div_run_reg    <= 1'b0;
                        mean_reg[j_reg] <= div_q;
                        out_reg[pors_pkg::POLY_W-1-j_reg*CW -: CW] <= div_q;
                        j_reg <= j_reg + 1'b1;
                        if (j_reg == 3'(NC-1)) begin
                            age_reg   <= '0;
                            if (!second_reg && valid_reg >= avg_c) state_reg <= ST_DIST_RD;
                            else state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DIST_RD: begin
                    if (age_reg == fill_reg) begin
                        taken_reg <= '0;
                        k_reg     <= '0;
                        for (int i = 0; i < NC; i++) sum_reg[i] <= '0;
                        age_reg   <= '0;
                        best_reg  <= fill_reg;
                        state_reg <= ST_SEL_RD;
                    end else begin
                        j_reg     <= '0;
                        dacc_reg  <= '0;
                        state_reg <= ST_DIST_ACC;
                    end
                end
                ST_DIST_ACC: begin
                    if (j_reg == 3'(NC-1)) begin
                        dist_reg[age_reg[SW-1:0]] <= dist_c;
                        age_reg   <= age_reg + 1'b1;
                        state_reg <= ST_DIST_RD;
                    end else begin
                        dacc_reg  <= dist_c;
                    end
                    j_reg <= j_reg + 1'b1;
                end
                ST_SEL_RD: begin
                    // scan for the lowest untaken distance, older wins ties
                    if (age_reg == fill_reg) begin
                        state_reg <= (best_reg == fill_reg || k_reg == avg_c)
                                   ? ST_SEL_ACC : ST_SEL_ADD_RD;
                    end else begin
                        if (!taken_reg[age_reg[SW-1:0]] && (best_reg == fill_reg
                            || dist_reg[age_reg[SW-1:0]] < best_d_reg)) begin
                            best_reg   <= age_reg;
                            best_d_reg <= dist_reg[age_reg[SW-1:0]];
                        end
                        age_reg <= age_reg + 1'b1;
                    end
                end
                ST_SEL_ADD_RD: begin
                    state_reg <= ST_SEL_ADD;
                end
                ST_SEL_ADD: begin
                    taken_reg[best_reg[SW-1:0]] <= 1'b1;
                    for (int i = 0; i < NC; i++)
                        sum_reg[i] <= sum_reg[i] + pors_pkg::SUM_W'(rd_c[i]);
                    k_reg    <= k_reg + 1'b1;
                    age_reg  <= '0;
                    best_reg <= fill_reg;
                    state_reg <= (k_reg + 1'b1 == avg_c) ? ST_SEL_ACC : ST_SEL_RD;
                end
                ST_SEL_ACC: begin
                    second_reg <= 1'b1;
                    j_reg      <= '0;
                    state_reg  <= ST_DIV2;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`include "polygon_outlier_rejecting_smoother_assert.svh"

    // no new request while a result is pending
    `POS_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready, "accept while result pending")
    // fill never exceeds the history depth
    `POS_ASSERT_IMP(a_fill_range, aclk, aresetn, 1'b1, fill_reg <= FW'(pors_pkg::HISTORY_DEPTH), "fill overflow")
    // an accepted request leaves idle at once
    `POS_ASSERT_NEXT(a_leave_idle, aclk, aresetn, s_valid && s_ready, state_reg == ST_WRITE, "no write after accept")
endmodule

// File: rtl/pors_ram.sv
// generic single port ram with registered read
module pors_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/pors_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module pors_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [pors_pkg::SUM_W-1:0]  dividend,
    input  logic [pors_pkg::FILL_W-1:0]        divisor,
    output logic                               busy,
    output logic signed [pors_pkg::COORD_WIDTH-1:0] quotient
);
    localparam int W = pors_pkg::SUM_W;

    logic [W-1:0]                 quo_reg;
    logic [W-1:0]                 rem_reg;
    logic [pors_pkg::FILL_W-1:0]  den_reg;
    logic                         neg_reg;
    logic [pors_pkg::CNT_W-1:0]   cnt_reg;
    logic                         busy_reg;
    logic [W:0]                   trial;
    logic [W-1:0]                 quo_fix;

    assign trial   = {rem_reg, quo_reg[W-1]} - {{(W+1-pors_pkg::FILL_W){1'b0}}, den_reg};
    assign busy    = busy_reg;
    assign quo_fix = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = quo_fix[pors_pkg::COORD_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= pors_pkg::CNT_W'(W);
            neg_reg  <= dividend[W-1];
            quo_reg  <= dividend[W-1] ? W'(-dividend) : W'(dividend);
            rem_reg  <= '0;
            den_reg  <= divisor;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == pors_pkg::CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end
endmodule

// File: dv/pors_smoothing_checker.sv
// watches the smoother's channels, predicts each smoothed polygon and compares
`timescale 1ns / 100ps

module pors_smoothing_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  pors_pkg::poly_in_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  pors_pkg::poly_out_t             m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [pors_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pors_pkg::CFG_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              pending_polys,
    output int                              smoothed_seen
);
    localparam int NC   = pors_pkg::NCOORD;
    localparam int HD   = pors_pkg::HISTORY_DEPTH;
    localparam int CW   = pors_pkg::COORD_WIDTH;
    localparam int PW   = pors_pkg::POLY_W;
    localparam int PRED_DEPTH = 64;

    longint                     history_poly [HD][NC];
    int                         history_fill;
    int                         oldest_slot;
    logic [pors_pkg::CFG_W-1:0] keep_count;
    logic [pors_pkg::CFG_W-1:0] average_count;
    // predicted results in order, read and write counters
    pors_pkg::poly_out_t        pred_mem [PRED_DEPTH];
    int                         pred_rd;
    int                         pred_wr;

    string coord_name [NC] = '{"bottom_left_x", "bottom_left_y", "bottom_right_x",
        "bottom_right_y", "top_right_x", "top_right_y", "top_left_x", "top_left_y"};

    function automatic void drop_oldest();
        oldest_slot  = (oldest_slot + 1) % HD;
        history_fill = history_fill - 1;
    endfunction

    function automatic pors_pkg::poly_out_t smooth_next(pors_pkg::poly_in_t p);
        logic [PW-1:0] raw;
        longint        c [NC];
        longint        total [NC];
        longint        center [NC];
        longint        l1_gap [HD];
        bit            taken [HD];
        longint        valid;
        longint        e;
        int            keep;
        int            avg;
        int            best;
        int            s;
        raw = p;
        for (int j = 0; j < NC; j++)
            c[j] = $signed(raw[PW-1-j*CW -: CW]);
        keep = (keep_count < 1) ? 1 : (keep_count > HD) ? HD : keep_count;
        avg  = (average_count < 1) ? 1 : average_count;
        if (history_fill >= HD)
            drop_oldest();
        s = (oldest_slot + history_fill) % HD;
        for (int j = 0; j < NC; j++)
            history_poly[s][j] = c[j];
        history_fill++;
        while (history_fill > keep)
            drop_oldest();
        // mean over valid entries, bottom left (0,0) marks an invalid polygon
        valid = 0;
        for (int j = 0; j < NC; j++)
            total[j] = 0;
        for (int a = 0; a < history_fill; a++) begin
            s = (oldest_slot + a) % HD;
            if (history_poly[s][0] != 0 || history_poly[s][1] != 0) begin
                valid++;
                for (int j = 0; j < NC; j++)
                    total[j] += history_poly[s][j];
            end
        end
        if (valid == 0) begin
            for (int j = 0; j < NC; j++)
                center[j] = c[j];
        end else begin
            for (int j = 0; j < NC; j++)
                center[j] = total[j] / valid;
            if (valid >= avg) begin
                // rank every entry by l1 distance, older wins on ties
                for (int a = 0; a < history_fill; a++) begin
                    s         = (oldest_slot + a) % HD;
                    l1_gap[a] = 0;
                    for (int j = 0; j < NC; j++) begin
                        e = center[j] - history_poly[s][j];
                        l1_gap[a] += (e < 0) ? -e : e;
                    end
                    taken[a] = 0;
                end
                for (int j = 0; j < NC; j++)
                    total[j] = 0;
                for (int k = 0; k < avg; k++) begin
                    best = history_fill;
                    for (int a = 0; a < history_fill; a++)
                        if (!taken[a] && (best == history_fill || l1_gap[a] < l1_gap[best]))
                            best = a;
                    if (best == history_fill)
                        break;
                    taken[best] = 1;
                    s = (oldest_slot + best) % HD;
                    for (int j = 0; j < NC; j++)
                        total[j] += history_poly[s][j];
                end
                for (int j = 0; j < NC; j++)
                    center[j] = total[j] / avg;
            end
        end
        for (int j = 0; j < NC; j++)
            raw[PW-1-j*CW -: CW] = center[j][CW-1:0];
        return pors_pkg::poly_out_t'(raw);
    endfunction

    always @(posedge aclk) begin
        logic [PW-1:0] want;
        logic [PW-1:0] got;
        logic          bad;
        if (!aresetn) begin
            history_fill  = 0;
            oldest_slot   = 0;
            keep_count    = 10;
            average_count = 5;
            pred_rd       = 0;
            pred_wr       = 0;
            fail_count    = 0;
            smoothed_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    pors_pkg::CFG_KEEP_COUNT:    keep_count = cfg_data;
                    pors_pkg::CFG_AVERAGE_COUNT: average_count = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                smoothed_seen++;
                if (pred_wr == pred_rd) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: smoothed polygon with none outstanding: %h", $time, m_data);
                end else begin
                    want    = pred_mem[pred_rd % PRED_DEPTH];
                    pred_rd = pred_rd + 1;
                    got     = m_data;
                    bad     = 0;
                    for (int j = 0; j < NC; j++)
                        if (want[PW-1-j*CW -: CW] !== got[PW-1-j*CW -: CW]) begin
                            bad = 1;
                            if (fail_count < 10)
                                $display("%0t: %s expected %0d got %0d", $time, coord_name[j],
                                    $signed(want[PW-1-j*CW -: CW]),
                                    $signed(got[PW-1-j*CW -: CW]));
                        end
                    if (bad)
                        fail_count++;
                end
            end
            if (s_valid && s_ready) begin
                pred_mem[pred_wr % PRED_DEPTH] = smooth_next(s_data);
                pred_wr = pred_wr + 1;
            end
        end
        pending_polys = pred_wr - pred_rd;
    end
endmodule

// File: dv/tb_polygon_outlier_rejecting_smoother.sv
// stimulus and verdict for the polygon smoother regression
`timescale 1ns / 100ps

module tb_polygon_outlier_rejecting_smoother;
    localparam int NC = pors_pkg::NCOORD;
    localparam int CW = pors_pkg::COORD_WIDTH;
    localparam int PW = pors_pkg::POLY_W;

    logic                            aclk      = 0;
    logic                            aresetn   = 0;
    logic                            s_valid   = 0;
    logic                            s_ready;
    pors_pkg::poly_in_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 0;
    pors_pkg::poly_out_t             m_data;
    logic                            cfg_valid = 0;
    logic                            cfg_ready;
    logic [pors_pkg::CFG_ADDR_W-1:0] cfg_addr  = pors_pkg::CFG_KEEP_COUNT;
    logic [pors_pkg::CFG_W-1:0]      cfg_data  = '0;

    int fail_count;
    int pending_polys;
    int smoothed_seen;

    // sender burst bookkeeping
    int burst_left = 1;
    int polys_sent = 0;
    // long receiver hold-off requests, served by the receiver process
    int hold_asked  = 0;
    int hold_served = 0;
    // the lane that well-formed polygons jitter around
    int lane [NC];

    // window / average settings per phase: shrink, extremes and out of range values
    int keep_plan [10] = '{16, 3, 16, 1, 0, 31, 16, 5, 12, 2};
    int avg_plan  [10] = '{4, 2, 16, 1, 0, 31, 1, 16, 6, 1};

    polygon_outlier_rejecting_smoother dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    pors_smoothing_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_polys (pending_polys),
        .smoothed_seen (smoothed_seen)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // safety net far beyond the slowest legal run
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // offer one polygon, hold it until accepted, then maybe start a gap
    task automatic push_poly(input pors_pkg::poly_in_t p);
        int gap;
        s_data  <= p;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        polys_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic write_reg(input logic [pors_pkg::CFG_ADDR_W-1:0] idx, input int value);
        cfg_addr  <= idx;
        cfg_data  <= value[pors_pkg::CFG_W-1:0];
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // sender pauses until every outstanding result has drained
    task automatic drain();
        s_valid <= 0;
        while (pending_polys != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic pors_pkg::poly_in_t pack_poly(input int v [NC]);
        logic [PW-1:0] raw;
        for (int j = 0; j < NC; j++)
            raw[PW-1-j*CW -: CW] = v[j][CW-1:0];
        return pors_pkg::poly_in_t'(raw);
    endfunction

    function automatic pors_pkg::poly_in_t same_poly(input int value);
        int v [NC];
        for (int j = 0; j < NC; j++)
            v[j] = value;
        return pack_poly(v);
    endfunction

    // mostly lane-like polygons, some outliers, invalid ones and full-range noise
    function automatic pors_pkg::poly_in_t random_poly();
        int v [NC];
        int pick;
        pick = $urandom_range(0, 99);
        for (int j = 0; j < NC; j++) begin
            if (pick < 65)
                v[j] = lane[j] + $signed($urandom_range(0, 16)) - 8;
            else if (pick < 78)
                v[j] = lane[j] + $signed($urandom_range(0, 8000)) - 4000;
            else
                v[j] = $urandom;
        end
        // invalid polygon: bottom left vertex at the origin
        if (pick >= 78 && pick < 88) begin
            v[0] = 0;
            v[1] = 0;
        end
        // repeats of the lane itself give equal distances
        if (pick >= 60 && pick < 65)
            for (int j = 0; j < NC; j++)
                v[j] = lane[j];
        return pack_poly(v);
    endfunction

    // receiver: its own stall pattern, plus long hold-offs on request
    initial begin
        int mode;
        int span;
        @(posedge aclk);
        forever begin
            if (hold_asked != hold_served) begin
                m_ready <= 0;
                repeat (700) @(posedge aclk);
                hold_served++;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 400);
                repeat (span) begin
                    case (mode)
                        0:       m_ready <= 1;
                        1:       m_ready <= ($urandom_range(0, 1) == 0);
                        2:       m_ready <= ($urandom_range(0, 4) == 0);
                        default: m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int v [NC];
        int waited;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        repeat (2) @(posedge aclk);

        // directed requests under the reset window and average count
        push_poly(same_poly(0));             // nothing valid yet: passthrough
        push_poly(same_poly(32767));
        push_poly(same_poly(-32768));
        push_poly(same_poly(-1));
        push_poly(same_poly(1));
        push_poly(same_poly(16'h5555));
        push_poly(same_poly(-21846));        // 0xaaaa pattern
        v = '{0, 0, 32767, -32768, 32767, -32768, 32767, -32768};
        push_poly(pack_poly(v));             // invalid despite extreme vertices
        v = '{0, 1, -5, 7, 100, -100, 3, 3};
        push_poly(pack_poly(v));             // x zero alone is still valid
        v = '{1, 0, -5, 7, 100, -100, 3, 3};
        push_poly(pack_poly(v));
        v = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        push_poly(pack_poly(v));
        for (int i = 0; i < 6; i++)
            push_poly(same_poly(-7));        // equal polygons, ties by age
        push_poly(same_poly(0));
        push_poly(same_poly(0));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(pors_pkg::CFG_KEEP_COUNT, keep_plan[ph]);
            write_reg(pors_pkg::CFG_AVERAGE_COUNT, avg_plan[ph]);
            for (int j = 0; j < NC; j++)
                lane[j] = $signed($urandom_range(0, 2000)) - 1000;
            for (int i = 0; i < 160; i++) begin
                // long receiver hold-off while we keep offering
                if (i == 40 && (ph == 0 || ph == 6))
                    hold_asked++;
                if (i == 100 && ph == 2)
                    drain();
                push_poly(random_poly());
            end
            drain();
        end

        waited = 0;
        while (pending_polys != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (600) @(posedge aclk);

        $display("sent %0d polygons over 10 window/average settings, %0d smoothed results",
            polys_sent, smoothed_seen);
        $display("covered invalid, passthrough, outlier, tie and full-range polygons");
        if (fail_count == 0 && pending_polys == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
